### hdl/dtbm_pkg.sv
`timescale 1ns / 1ps

package dtbm_pkg;

  // Field widths fixed by the request and result formats
  localparam int STATE_W = 10;
  localparam int BYTE_W  = 8;

  // Symbols per state and default automaton size
  localparam int ALPHABET     = 256;
  localparam int NUM_STATES_D = 1024;

  // Width wide enough to hold any state index the parameter range allows
  localparam int IDX_EXT_W = 17;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_MARK   = 2'd1,
    REQ_SCAN   = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_TRANS,
    ST_ACC,
    ST_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic do_write;
    logic rd_trans;
    logic rd_acc;
    logic respond;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
  } ctrl_sts_t;

  // True when a state index lies inside the table
  function automatic logic state_ok(input logic [STATE_W-1:0] st, input int unsigned n);
    return (32'(st) < n);
  endfunction

endpackage

### hdl/dtbm_ctrl.sv
`timescale 1ns / 1ps

module dtbm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dtbm_pkg::req_t      req_type,
  input  dtbm_pkg::ctrl_sts_t sts,
  output dtbm_pkg::ctrl_cmd_t cmd,
  output logic                busy
);
  import dtbm_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts the memory clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (req_type inside {REQ_WRITE, REQ_MARK}) state_next = ST_WRITE;
          else state_next = ST_TRANS;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_TRANS: state_next = ST_ACC;
      ST_ACC:   state_next = ST_RESP;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clear_en = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_WRITE: cmd.do_write = 1'b1;
      ST_TRANS: cmd.rd_trans = 1'b1;
      ST_ACC:   cmd.rd_acc   = 1'b1;
      ST_RESP:  cmd.respond  = 1'b1;
      default:  cmd          = '0;
    endcase
  end

  // Checks
  a_clear_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && sts.clear_last) |=> (state == ST_IDLE))
    else $error("clearing pass did not end in idle");

  a_read_chain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRANS) |=> (state == ST_ACC) ##1 (state == ST_RESP))
    else $error("read sequence broken");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (state == ST_IDLE && !cmd.clear_en))
    else $error("request captured while busy");

endmodule

### hdl/dtbm_datapath.sv
`timescale 1ns / 1ps

module dtbm_datapath #(
  parameter int NUM_STATES = dtbm_pkg::NUM_STATES_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dtbm_pkg::ctrl_cmd_t           cmd,
  output dtbm_pkg::ctrl_sts_t           sts,
  input  dtbm_pkg::req_t                req_type,
  input  logic [dtbm_pkg::STATE_W-1:0]  state_index,
  input  logic [dtbm_pkg::BYTE_W-1:0]   byte_value,
  input  logic [dtbm_pkg::STATE_W-1:0]  next_state,
  input  logic                          last_byte,
  output logic                          done,
  output logic [dtbm_pkg::STATE_W-1:0]  state_out,
  output logic                          match_now,
  output logic                          match_seen,
  output logic                          buffer_done
);
  import dtbm_pkg::*;

  localparam int SW    = $clog2(NUM_STATES);
  localparam int AW    = SW + BYTE_W;
  localparam int DEPTH = NUM_STATES * ALPHABET;

  // Map a state to its row in the stores
  function automatic logic [SW-1:0] st_idx(input logic [STATE_W-1:0] st);
    logic [IDX_EXT_W-1:0] ext;
    ext = IDX_EXT_W'(st);
    return ext[SW-1:0];
  endfunction

  // Stores
  logic [STATE_W-1:0] tmem [DEPTH];
  logic               amem [NUM_STATES];

  // Captured request
  req_t               rq_type;
  logic [STATE_W-1:0] rq_state;
  logic [BYTE_W-1:0]  rq_sym;
  logic [STATE_W-1:0] rq_tgt;
  logic               rq_last;

  // Scan state
  logic [STATE_W-1:0] cur_state;
  logic               any_match;

  // Clearing counter
  logic [AW-1:0]      clr_cnt;

  // Read pipeline
  logic [STATE_W-1:0] tr_rd;
  logic               src_ok;
  logic [STATE_W-1:0] nxt;
  logic               nxt_ok;
  logic               acc_rd;

  logic [STATE_W-1:0] src_state;
  logic [STATE_W-1:0] nxt_val;
  logic               hit;

  assign sts.clear_last = (clr_cnt == AW'(DEPTH - 1));
  assign src_state      = (rq_type == REQ_SCAN) ? cur_state : rq_state;
  assign nxt_val        = src_ok ? tr_rd : '0;
  assign hit            = acc_rd & nxt_ok;

  // Hold the request while it is worked on
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq_type  <= req_type;
      rq_state <= state_index;
      rq_sym   <= byte_value;
      rq_tgt   <= next_state;
      rq_last  <= last_byte;
    end
  end

  // Advance the clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en && !sts.clear_last) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Transition memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      tmem[clr_cnt] <= '0;
    end else if (cmd.do_write && rq_type == REQ_WRITE && state_ok(rq_state, NUM_STATES)) begin
      tmem[{st_idx(rq_state), rq_sym}] <= rq_tgt;
    end
    if (cmd.rd_trans) begin
      tr_rd  <= tmem[{st_idx(src_state), rq_sym}];
      src_ok <= state_ok(src_state, NUM_STATES);
    end
  end

  // Accepting bitmap: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      amem[clr_cnt[AW-1:BYTE_W]] <= 1'b0;
    end else if (cmd.do_write && rq_type == REQ_MARK && state_ok(rq_state, NUM_STATES)) begin
      amem[st_idx(rq_state)] <= 1'b1;
    end
    if (cmd.rd_acc) begin
      acc_rd <= amem[st_idx(nxt_val)];
      nxt    <= nxt_val;
      nxt_ok <= state_ok(nxt_val, NUM_STATES);
    end
  end

  // Update the scan state on a scan result
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      any_match <= 1'b0;
    end else if (cmd.respond && rq_type == REQ_SCAN) begin
      if (rq_last) begin
        cur_state <= '0;
        any_match <= 1'b0;
      end else begin
        cur_state <= nxt;
        any_match <= any_match | hit;
      end
    end
  end

  // Drive the result registers
  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      state_out   <= '0;
      match_now   <= 1'b0;
      match_seen  <= 1'b0;
      buffer_done <= 1'b0;
    end else if (cmd.respond) begin
      state_out   <= nxt;
      match_now   <= hit;
      match_seen  <= (rq_type == REQ_SCAN) ? (any_match | hit) : 1'b0;
      buffer_done <= (rq_type == REQ_SCAN) ? rq_last : 1'b0;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.do_write | cmd.respond;
    end
  end

  // Checks
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.do_write || cmd.respond))
    else $error("result strobe without a finished request");

  a_buffer_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.respond && rq_type == REQ_SCAN && rq_last) |=> (cur_state == '0 && !any_match))
    else $error("scan state not cleared after last byte");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.do_write |=> (done && state_out == '0 && !match_now && !match_seen && !buffer_done))
    else $error("write result not zero");

  a_lookup_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.respond && rq_type == REQ_LOOKUP) |=> ($stable(cur_state) && !match_seen && !buffer_done))
    else $error("lookup disturbed scan state");

endmodule

### hdl/dfa_table_byte_matcher_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Fields
// request   in         start, busy               req_type state_index byte_value
//                                                next_state last_byte
// result    out        done (one-cycle strobe)   state_out match_now match_seen
//                                                buffer_done
//
// A request is taken at a clock edge with start high and busy low.
// Write and mark requests hold busy high while the store is written (state WRITE).
// Scan and lookup requests hold busy high through the transition memory read, the
// dependent accepting-bitmap read and the response (states TRANS, ACC, RESP).
// The result strobe rises on the cycle busy falls; the receiver cannot stall.
// After rst (synchronous, active high) a clearing pass zeroes every entry of both
// stores with busy high.

module dfa_table_byte_matcher_top #(
  parameter int NUM_STATES = dtbm_pkg::NUM_STATES_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [dtbm_pkg::STATE_W-1:0]  state_index,
  input  logic [dtbm_pkg::BYTE_W-1:0]   byte_value,
  input  logic [dtbm_pkg::STATE_W-1:0]  next_state,
  input  logic                          last_byte,
  output logic                          done,
  output logic [dtbm_pkg::STATE_W-1:0]  state_out,
  output logic                          match_now,
  output logic                          match_seen,
  output logic                          buffer_done
);
  import dtbm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  req_t      req_code;

  assign req_code = req_t'(req_type);

  // Sequence the requests
  dtbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_code),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Stores, scan state and results
  dtbm_datapath #(
    .NUM_STATES (NUM_STATES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_code),
    .state_index (state_index),
    .byte_value  (byte_value),
    .next_state  (next_state),
    .last_byte   (last_byte),
    .done        (done),
    .state_out   (state_out),
    .match_now   (match_now),
    .match_seen  (match_seen),
    .buffer_done (buffer_done)
  );

endmodule
